/* design/chip8_pkg.sv */
// ----------------------------------------------------------------------------
// chip8_pkg
// shared types, constants and the font rom for the chip8 instruction core
// ----------------------------------------------------------------------------
package chip8_pkg;

  localparam int MEMORY_BYTES  = 4096;
  localparam int ADDR_W        = $clog2(MEMORY_BYTES);
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
  localparam int COL_W         = $clog2(SCREEN_WIDTH);
  localparam int STACK_DEPTH   = 16;
  localparam int SP_W          = $clog2(STACK_DEPTH);
  localparam int NUM_V         = 16;
  localparam int FONT_BYTES    = 80;
  localparam int FONT_W        = $clog2(FONT_BYTES);
  localparam logic [ADDR_W-1:0] PC_START = ADDR_W'(12'h200);
  localparam logic [3:0] FLAG_REG = 4'hF;

  // item operations
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_EXEC  = 2'd1,
    OP_READ  = 2'd2,
    OP_ROW   = 2'd3
  } item_op_t;

  // instruction groups (top nibble)
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SEV  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNEV = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV  = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  // low byte codes
  localparam logic [7:0] KK_CLS   = 8'hE0;
  localparam logic [7:0] KK_RET   = 8'hEE;
  localparam logic [7:0] KK_SKP   = 8'h9E;
  localparam logic [7:0] KK_SKNP  = 8'hA1;
  localparam logic [7:0] KK_GETDT = 8'h07;
  localparam logic [7:0] KK_WAITK = 8'h0A;
  localparam logic [7:0] KK_SETDT = 8'h15;
  localparam logic [7:0] KK_SETST = 8'h18;
  localparam logic [7:0] KK_ADDI  = 8'h1E;
  localparam logic [7:0] KK_FONT  = 8'h29;
  localparam logic [7:0] KK_BCD   = 8'h33;
  localparam logic [7:0] KK_STORE = 8'h55;
  localparam logic [7:0] KK_LOAD  = 8'h65;

  // alu codes (low nibble of group 8)
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [7:0]        write_byte;
    logic [15:0]       key_state;
    logic [7:0]        random_byte;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       program_counter;
    logic                    display_changed;
    logic                    sound_on;
    logic                    unknown_opcode;
    logic [SCREEN_WIDTH-1:0] read_data;
  } result_t;

  typedef enum logic [2:0] {
    MA_ITEM, MA_PC, MA_PC1, MA_IDX, MA_IDX1, MA_IDX2, MA_IDX_CNT, MA_CLR
  } mem_addr_t;

  typedef enum logic [2:0] {
    MW_ITEM, MW_VQ, MW_HUND, MW_TENS, MW_ONES, MW_ZERO
  } mem_wdata_t;

  typedef enum logic [1:0] {VR_X, VR_Y, VR_ZERO, VR_CNT} v_raddr_t;
  typedef enum logic [1:0] {VA_X, VA_FLAG, VA_CNT} v_waddr_t;

  typedef enum logic [2:0] {
    VW_KK, VW_ADD, VW_ALU, VW_RND, VW_DT, VW_KEY, VW_MQ, VW_FLAG
  } v_wdata_t;

  typedef enum logic [2:0] {
    PC_HOLD, PC_ADD2, PC_BACK2, PC_JUMP, PC_JUMPV, PC_RET
  } pc_op_t;

  typedef enum logic [1:0] {I_HOLD, I_NNN, I_ADD, I_FONT} idx_op_t;
  typedef enum logic [1:0] {SP_HOLD, SP_PUSH, SP_POP} sp_op_t;
  typedef enum logic {SR_ITEM, SR_DRAW} scr_row_t;
  typedef enum logic [1:0] {FL_HOLD, FL_ALU, FL_CLR, FL_HIT} flag_op_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ISSUE, S_FETCH1, S_FETCH2, S_RDX, S_RDY, S_RDB,
    S_EXEC, S_RET, S_FLAG, S_DRAW_RD, S_DRAW_WR, S_BCD_T, S_BCD_O,
    S_STR_RD, S_STR_WR, S_LD_RD, S_LD_WR, S_TICK, S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic       latch_item;
    logic       res_clr;
    logic       mem_re;
    logic       mem_we;
    mem_addr_t  mem_addr;
    mem_wdata_t mem_wdata;
    logic       op_hi_ld;
    logic       op_lo_ld;
    logic       v_re;
    v_raddr_t   v_raddr;
    logic       v_we;
    v_waddr_t   v_waddr;
    v_wdata_t   v_wdata;
    logic       a_ld;
    logic       b_ld;
    pc_op_t     pc_op;
    idx_op_t    idx_op;
    sp_op_t     sp_op;
    logic       stack_we;
    logic       stack_re;
    logic       dt_ld;
    logic       st_ld;
    logic       tick;
    logic       scr_clear;
    logic       scr_re;
    logic       scr_we;
    scr_row_t   scr_row;
    flag_op_t   flag_op;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       clr_inc;
    logic       disp_set;
    logic       unk_set;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    item_op_t    item_op;
    logic [15:0] opcode;
    logic        a_eq_kk;
    logic        a_eq_b;
    logic        key_bit;
    logic        key_any;
    logic        draw_go;
    logic        cnt_eq_x;
    logic        clr_last;
    logic        out_free;
  } dp_status_t;

  localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  function automatic logic [7:0] font_byte(input logic [FONT_W-1:0] i);
    logic [7:0] r;
    r = 8'h00;
    if (int'(i) < FONT_BYTES) begin
      r = FONT_ROM[i];
    end
    return r;
  endfunction

endpackage

/* design/chip8_instruction_core.sv */
// ----------------------------------------------------------------------------
// chip8_instruction_core
// chip8 interpreter core: memory, screen, registers, one item per request beat
// ----------------------------------------------------------------------------
// request channel: request_valid / request_stall / request carry one item
// (write byte, execute one instruction, read byte, read screen row).
// result channel: result_valid / result_stall / result, one beat per item.
// after reset the core sweeps main memory to zero with request_stall high;
// font bytes come from a rom and are never written. all memory traffic
// goes through the single byte port.
// one item is in flight at a time; the next one is taken as soon as the
// result beat sits in the output register, so a stalled receiver holds
// only that register and blocks the core only when a second result is ready.
// the output register holds its beat unchanged while result_stall is high.
// ----------------------------------------------------------------------------
module chip8_instruction_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 request_valid,
  output logic                 request_stall,
  input  chip8_pkg::request_t  request,
  output logic                 result_valid,
  input  logic                 result_stall,
  output chip8_pkg::result_t   result
);

  // command and status between sequencer and datapath
  chip8_pkg::dp_cmd_t    cmd;
  chip8_pkg::dp_status_t status;

  // sequencer: clear sweep, dispatch and instruction sequencing
  chip8_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .status        (status),
    .cmd           (cmd)
  );

  // datapath: memories, registers, alu, result register
  chip8_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // a waiting result beat is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(result_valid && result_stall))
    else $error("result register overwritten while stalled");

  // an accepted beat makes the core busy in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (request_valid && !request_stall) |=> request_stall)
    else $error("core took a second beat without going busy");

  // screen change and unknown opcode come from disjoint instruction groups
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.display_changed && result.unknown_opcode))
    else $error("display change and unknown opcode in one result");

endmodule

/* design/chip8_datapath.sv */
// ----------------------------------------------------------------------------
// chip8_datapath
// memories, registers, alu and result register driven by controller commands
// ----------------------------------------------------------------------------
module chip8_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  chip8_pkg::request_t    request,
  input  chip8_pkg::dp_cmd_t     cmd,
  output chip8_pkg::dp_status_t  status,
  output logic                   result_valid,
  input  logic                   result_stall,
  output chip8_pkg::result_t     result
);

  localparam int AW = chip8_pkg::ADDR_W;

  chip8_pkg::request_t item;
  logic [7:0]  op_hi, op_lo;
  logic [15:0] opcode;
  logic [3:0]  x_idx, y_idx, n_val;
  logic [7:0]  kk;
  logic [AW-1:0] nnn;

  logic [AW-1:0] pc, clr_cnt;
  logic [15:0]   idx;
  logic [chip8_pkg::SP_W-1:0] sp, sp_pop, sp_push;
  logic [7:0] dt, st, a, b;
  logic [3:0] cnt;
  logic flag, disp, unk;

  // main memory
  logic [7:0] ram [chip8_pkg::MEMORY_BYTES];
  logic [7:0] ram_q, font_q, mem_q, mem_wd;
  logic font_hit;
  logic [AW-1:0] mem_a;
  logic mem_we_ok;

  // data registers
  logic [7:0] vram [chip8_pkg::NUM_V];
  logic [chip8_pkg::NUM_V-1:0] v_ok;
  logic [7:0] v_raw, vq, v_wd;
  logic v_q_ok;
  logic [3:0] v_ra, v_wa;

  // return stack
  logic [AW-1:0] stack_ram [chip8_pkg::STACK_DEPTH];
  logic [AW-1:0] stack_q;

  // screen
  logic [chip8_pkg::SCREEN_WIDTH-1:0] scr [chip8_pkg::SCREEN_HEIGHT];
  logic [chip8_pkg::SCREEN_HEIGHT-1:0] scr_ok;
  logic [chip8_pkg::SCREEN_WIDTH-1:0] scr_raw, scr_q, spr;
  logic scr_q_ok;
  logic [chip8_pkg::ROW_W-1:0] row_a, draw_row;

  // alu and helpers
  logic [8:0] sum;
  logic [7:0] alu_r, rem, tens, ones, hund;
  logic alu_f;
  logic [14:0] tens_mul;
  logic [3:0] key_idx;
  logic [6:0] font_addr;
  logic [chip8_pkg::SCREEN_WIDTH-1:0] read_data;

  assign opcode = {op_hi, op_lo};
  assign x_idx  = opcode[11:8];
  assign y_idx  = opcode[7:4];
  assign n_val  = opcode[3:0];
  assign kk     = opcode[7:0];
  assign nnn    = opcode[AW-1:0];

  assign sp_pop  = (sp == '0) ? chip8_pkg::SP_W'(chip8_pkg::STACK_DEPTH - 1) : sp - 1'b1;
  assign sp_push = (sp == chip8_pkg::SP_W'(chip8_pkg::STACK_DEPTH - 1)) ? '0 : sp + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item <= request;
    end
    if (cmd.op_hi_ld) begin
      op_hi <= mem_q;
    end
    if (cmd.op_lo_ld) begin
      op_lo <= mem_q;
    end
    if (cmd.a_ld) begin
      a <= vq;
    end
    if (cmd.b_ld) begin
      b <= vq;
    end
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
    unique case (cmd.flag_op)
      chip8_pkg::FL_ALU: flag <= alu_f;
      chip8_pkg::FL_CLR: flag <= 1'b0;
      chip8_pkg::FL_HIT: flag <= flag | (|(scr_q & spr));
      default:           flag <= flag;
    endcase
  end

  // memory address and write data
  always_comb begin
    unique case (cmd.mem_addr)
      chip8_pkg::MA_ITEM:    mem_a = item.address;
      chip8_pkg::MA_PC:      mem_a = pc;
      chip8_pkg::MA_PC1:     mem_a = pc + 1'b1;
      chip8_pkg::MA_IDX:     mem_a = idx[AW-1:0];
      chip8_pkg::MA_IDX1:    mem_a = idx[AW-1:0] + 1'b1;
      chip8_pkg::MA_IDX2:    mem_a = idx[AW-1:0] + AW'(2);
      chip8_pkg::MA_IDX_CNT: mem_a = idx[AW-1:0] + AW'(cnt);
      default:               mem_a = clr_cnt;
    endcase
  end

  // bcd digits: hundreds by compare, tens by reciprocal multiply
  always_comb begin
    if (a >= 8'd200) begin
      hund = 8'd2;
      rem  = a - 8'd200;
    end else if (a >= 8'd100) begin
      hund = 8'd1;
      rem  = a - 8'd100;
    end else begin
      hund = 8'd0;
      rem  = a;
    end
    tens_mul = 15'(rem) * 15'd205;
    tens     = {4'b0, tens_mul[14:11]};
    ones     = rem - 8'(tens * 8'd10);
  end

  always_comb begin
    unique case (cmd.mem_wdata)
      chip8_pkg::MW_ITEM: mem_wd = item.write_byte;
      chip8_pkg::MW_VQ:   mem_wd = vq;
      chip8_pkg::MW_HUND: mem_wd = hund;
      chip8_pkg::MW_TENS: mem_wd = tens;
      chip8_pkg::MW_ONES: mem_wd = ones;
      default:            mem_wd = 8'h00;
    endcase
  end

  // font area is read only
  assign mem_we_ok = cmd.mem_we && (mem_a >= AW'(chip8_pkg::FONT_BYTES));
  assign font_addr = mem_a[6:0];

  always_ff @(posedge clk) begin
    if (mem_we_ok) begin
      ram[mem_a] <= mem_wd;
    end
    if (cmd.mem_re) begin
      ram_q    <= ram[mem_a];
      font_hit <= mem_a < AW'(chip8_pkg::FONT_BYTES);
      font_q   <= chip8_pkg::font_byte(font_addr);
    end
  end

  assign mem_q = font_hit ? font_q : ram_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_inc) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // data register file
  always_comb begin
    unique case (cmd.v_raddr)
      chip8_pkg::VR_X:    v_ra = x_idx;
      chip8_pkg::VR_Y:    v_ra = y_idx;
      chip8_pkg::VR_ZERO: v_ra = 4'h0;
      default:            v_ra = cnt;
    endcase
    unique case (cmd.v_waddr)
      chip8_pkg::VA_X:    v_wa = x_idx;
      chip8_pkg::VA_FLAG: v_wa = chip8_pkg::FLAG_REG;
      default:            v_wa = cnt;
    endcase
  end

  always_comb begin
    sum   = {1'b0, a} + {1'b0, b};
    alu_r = a;
    alu_f = 1'b0;
    unique case (n_val)
      chip8_pkg::ALU_MOV:  alu_r = b;
      chip8_pkg::ALU_OR:   alu_r = a | b;
      chip8_pkg::ALU_AND:  alu_r = a & b;
      chip8_pkg::ALU_XOR:  alu_r = a ^ b;
      chip8_pkg::ALU_ADD: begin
        alu_r = sum[7:0];
        alu_f = sum[8];
      end
      chip8_pkg::ALU_SUB: begin
        alu_r = a - b;
        alu_f = a > b;
      end
      chip8_pkg::ALU_SHR: begin
        alu_r = {1'b0, a[7:1]};
        alu_f = a[0];
      end
      chip8_pkg::ALU_SUBN: begin
        alu_r = b - a;
        alu_f = b > a;
      end
      chip8_pkg::ALU_SHL: begin
        alu_r = {a[6:0], 1'b0};
        alu_f = a[7];
      end
      default: alu_r = a;
    endcase
  end

  // lowest pressed key
  always_comb begin
    key_idx = 4'h0;
    for (int k = 15; k >= 0; k--) begin
      if (item.key_state[k]) begin
        key_idx = 4'(k);
      end
    end
  end

  always_comb begin
    unique case (cmd.v_wdata)
      chip8_pkg::VW_KK:  v_wd = kk;
      chip8_pkg::VW_ADD: v_wd = a + kk;
      chip8_pkg::VW_ALU: v_wd = alu_r;
      chip8_pkg::VW_RND: v_wd = item.random_byte & kk;
      chip8_pkg::VW_DT:  v_wd = dt;
      chip8_pkg::VW_KEY: v_wd = {4'h0, key_idx};
      chip8_pkg::VW_MQ:  v_wd = mem_q;
      default:           v_wd = {7'b0, flag};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.v_we) begin
      vram[v_wa] <= v_wd;
    end
    if (cmd.v_re) begin
      v_raw  <= vram[v_ra];
      v_q_ok <= v_ok[v_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_ok <= '0;
    end else if (cmd.v_we) begin
      v_ok[v_wa] <= 1'b1;
    end
  end

  assign vq = v_q_ok ? v_raw : 8'h00;

  // return stack
  always_ff @(posedge clk) begin
    if (cmd.stack_we) begin
      stack_ram[sp] <= pc;
    end
    if (cmd.stack_re) begin
      stack_q <= stack_ram[sp_pop];
    end
  end

  // screen rows
  assign draw_row = b[chip8_pkg::ROW_W-1:0] + chip8_pkg::ROW_W'(cnt);
  assign row_a    = (cmd.scr_row == chip8_pkg::SR_DRAW) ? draw_row
                                                        : item.address[chip8_pkg::ROW_W-1:0];
  assign spr      = {mem_q, {(chip8_pkg::SCREEN_WIDTH-8){1'b0}}} >> a[chip8_pkg::COL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.scr_we) begin
      scr[row_a] <= scr_q ^ spr;
    end
    if (cmd.scr_re) begin
      scr_raw  <= scr[row_a];
      scr_q_ok <= scr_ok[row_a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.scr_clear) begin
      scr_ok <= '0;
    end else if (cmd.scr_we) begin
      scr_ok[row_a] <= 1'b1;
    end
  end

  assign scr_q = scr_q_ok ? scr_raw : '0;

  // architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= chip8_pkg::PC_START;
      idx <= '0;
      sp  <= '0;
      dt  <= '0;
      st  <= '0;
    end else begin
      unique case (cmd.pc_op)
        chip8_pkg::PC_ADD2:  pc <= pc + AW'(2);
        chip8_pkg::PC_BACK2: pc <= pc - AW'(2);
        chip8_pkg::PC_JUMP:  pc <= nnn;
        chip8_pkg::PC_JUMPV: pc <= nnn + AW'(a);
        chip8_pkg::PC_RET:   pc <= stack_q;
        default:             pc <= pc;
      endcase
      unique case (cmd.idx_op)
        chip8_pkg::I_NNN:  idx <= {4'h0, nnn};
        chip8_pkg::I_ADD:  idx <= idx + {8'h00, a};
        chip8_pkg::I_FONT: idx <= {9'b0, 7'(a[3:0] * 7'd5)};
        default:           idx <= idx;
      endcase
      unique case (cmd.sp_op)
        chip8_pkg::SP_PUSH: sp <= sp_push;
        chip8_pkg::SP_POP:  sp <= sp_pop;
        default:            sp <= sp;
      endcase
      if (cmd.dt_ld) begin
        dt <= a;
      end else if (cmd.tick && dt != 8'h00) begin
        dt <= dt - 1'b1;
      end
      if (cmd.st_ld) begin
        st <= a;
      end else if (cmd.tick && st != 8'h00) begin
        st <= st - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_clr) begin
      disp <= 1'b0;
      unk  <= 1'b0;
    end else begin
      if (cmd.disp_set) begin
        disp <= 1'b1;
      end
      if (cmd.unk_set) begin
        unk <= 1'b1;
      end
    end
  end

  // result register
  always_comb begin
    unique case (chip8_pkg::item_op_t'(item.operation))
      chip8_pkg::OP_READ: read_data = {{(chip8_pkg::SCREEN_WIDTH-8){1'b0}}, mem_q};
      chip8_pkg::OP_ROW:  read_data = scr_q;
      default:            read_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.program_counter <= pc;
      result.display_changed <= disp;
      result.sound_on        <= st != 8'h00;
      result.unknown_opcode  <= unk;
      result.read_data       <= read_data;
    end
  end

  assign status.item_op  = chip8_pkg::item_op_t'(item.operation);
  assign status.opcode   = opcode;
  assign status.a_eq_kk  = a == kk;
  assign status.a_eq_b   = a == b;
  assign status.key_bit  = item.key_state[a[3:0]];
  assign status.key_any  = |item.key_state;
  assign status.draw_go  = (cnt < n_val) &&
                           (({1'b0, b[chip8_pkg::ROW_W-1:0]} + {2'b0, cnt}) <
                            6'(chip8_pkg::SCREEN_HEIGHT));
  assign status.cnt_eq_x = cnt == x_idx;
  assign status.clr_last = clr_cnt == AW'(chip8_pkg::MEMORY_BYTES - 1);
  assign status.out_free = !result_valid || !result_stall;

endmodule

/* design/chip8_ctrl.sv */
// ----------------------------------------------------------------------------
// chip8_ctrl
// sequencer: memory clear sweep, item dispatch, fetch, decode and execute
// ----------------------------------------------------------------------------
module chip8_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   request_valid,
  output logic                   request_stall,
  input  chip8_pkg::dp_status_t  status,
  output chip8_pkg::dp_cmd_t     cmd
);

  chip8_pkg::ctrl_state_t state, state_next;
  logic [3:0] grp, n_val;
  logic [7:0] kk;
  logic       x_zero;

  assign grp    = status.opcode[15:12];
  assign n_val  = status.opcode[3:0];
  assign kk     = status.opcode[7:0];
  assign x_zero = status.opcode[11:8] == 4'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chip8_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign request_stall = state != chip8_pkg::S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      chip8_pkg::S_CLEAR: begin
        cmd.mem_we    = 1'b1;
        cmd.mem_addr  = chip8_pkg::MA_CLR;
        cmd.mem_wdata = chip8_pkg::MW_ZERO;
        cmd.clr_inc   = 1'b1;
        if (status.clr_last) begin
          state_next = chip8_pkg::S_IDLE;
        end
      end
      chip8_pkg::S_IDLE: begin
        if (request_valid) begin
          cmd.latch_item = 1'b1;
          cmd.res_clr    = 1'b1;
          state_next     = chip8_pkg::S_ISSUE;
        end
      end
      chip8_pkg::S_ISSUE: begin
        unique case (status.item_op)
          chip8_pkg::OP_WRITE: begin
            cmd.mem_we    = 1'b1;
            cmd.mem_addr  = chip8_pkg::MA_ITEM;
            cmd.mem_wdata = chip8_pkg::MW_ITEM;
            state_next    = chip8_pkg::S_DONE;
          end
          chip8_pkg::OP_READ: begin
            cmd.mem_re   = 1'b1;
            cmd.mem_addr = chip8_pkg::MA_ITEM;
            state_next   = chip8_pkg::S_DONE;
          end
          chip8_pkg::OP_ROW: begin
            cmd.scr_re  = 1'b1;
            cmd.scr_row = chip8_pkg::SR_ITEM;
            state_next  = chip8_pkg::S_DONE;
          end
          default: begin
            cmd.mem_re   = 1'b1;
            cmd.mem_addr = chip8_pkg::MA_PC;
            state_next   = chip8_pkg::S_FETCH1;
          end
        endcase
      end
      chip8_pkg::S_FETCH1: begin
        cmd.op_hi_ld = 1'b1;
        cmd.mem_re   = 1'b1;
        cmd.mem_addr = chip8_pkg::MA_PC1;
        state_next   = chip8_pkg::S_FETCH2;
      end
      chip8_pkg::S_FETCH2: begin
        cmd.op_lo_ld = 1'b1;
        cmd.pc_op    = chip8_pkg::PC_ADD2;
        state_next   = chip8_pkg::S_RDX;
      end
      chip8_pkg::S_RDX: begin
        cmd.v_re    = 1'b1;
        cmd.v_raddr = (grp == chip8_pkg::GRP_JPV) ? chip8_pkg::VR_ZERO : chip8_pkg::VR_X;
        state_next  = chip8_pkg::S_RDY;
      end
      chip8_pkg::S_RDY: begin
        cmd.a_ld    = 1'b1;
        cmd.v_re    = 1'b1;
        cmd.v_raddr = chip8_pkg::VR_Y;
        state_next  = chip8_pkg::S_RDB;
      end
      chip8_pkg::S_RDB: begin
        cmd.b_ld   = 1'b1;
        state_next = chip8_pkg::S_EXEC;
      end
      chip8_pkg::S_EXEC: begin
        state_next = chip8_pkg::S_TICK;
        unique case (grp)
          chip8_pkg::GRP_SYS: begin
            if (kk == chip8_pkg::KK_CLS) begin
              cmd.scr_clear = 1'b1;
              cmd.disp_set  = 1'b1;
            end else if (kk == chip8_pkg::KK_RET && x_zero) begin
              cmd.sp_op    = chip8_pkg::SP_POP;
              cmd.stack_re = 1'b1;
              state_next   = chip8_pkg::S_RET;
            end
          end
          chip8_pkg::GRP_JP: cmd.pc_op = chip8_pkg::PC_JUMP;
          chip8_pkg::GRP_CALL: begin
            cmd.stack_we = 1'b1;
            cmd.sp_op    = chip8_pkg::SP_PUSH;
            cmd.pc_op    = chip8_pkg::PC_JUMP;
          end
          chip8_pkg::GRP_SE:
            cmd.pc_op = status.a_eq_kk ? chip8_pkg::PC_ADD2 : chip8_pkg::PC_HOLD;
          chip8_pkg::GRP_SNE:
            cmd.pc_op = status.a_eq_kk ? chip8_pkg::PC_HOLD : chip8_pkg::PC_ADD2;
          chip8_pkg::GRP_SEV:
            cmd.pc_op = status.a_eq_b ? chip8_pkg::PC_ADD2 : chip8_pkg::PC_HOLD;
          chip8_pkg::GRP_LD: begin
            cmd.v_we    = 1'b1;
            cmd.v_waddr = chip8_pkg::VA_X;
            cmd.v_wdata = chip8_pkg::VW_KK;
          end
          chip8_pkg::GRP_ADD: begin
            cmd.v_we    = 1'b1;
            cmd.v_waddr = chip8_pkg::VA_X;
            cmd.v_wdata = chip8_pkg::VW_ADD;
          end
          chip8_pkg::GRP_ALU: begin
            cmd.v_waddr = chip8_pkg::VA_X;
            cmd.v_wdata = chip8_pkg::VW_ALU;
            priority case (n_val)
              chip8_pkg::ALU_MOV, chip8_pkg::ALU_OR,
              chip8_pkg::ALU_AND, chip8_pkg::ALU_XOR: cmd.v_we = 1'b1;
              chip8_pkg::ALU_ADD, chip8_pkg::ALU_SUB, chip8_pkg::ALU_SHR,
              chip8_pkg::ALU_SUBN, chip8_pkg::ALU_SHL: begin
                cmd.v_we    = 1'b1;
                cmd.flag_op = chip8_pkg::FL_ALU;
                state_next  = chip8_pkg::S_FLAG;
              end
              default: cmd.v_we = 1'b0;
            endcase
          end
          chip8_pkg::GRP_SNEV:
            cmd.pc_op = status.a_eq_b ? chip8_pkg::PC_HOLD : chip8_pkg::PC_ADD2;
          chip8_pkg::GRP_LDI: cmd.idx_op = chip8_pkg::I_NNN;
          chip8_pkg::GRP_JPV: cmd.pc_op = chip8_pkg::PC_JUMPV;
          chip8_pkg::GRP_RND: begin
            cmd.v_we    = 1'b1;
            cmd.v_waddr = chip8_pkg::VA_X;
            cmd.v_wdata = chip8_pkg::VW_RND;
          end
          chip8_pkg::GRP_DRW: begin
            cmd.cnt_clr  = 1'b1;
            cmd.flag_op  = chip8_pkg::FL_CLR;
            cmd.disp_set = 1'b1;
            state_next   = chip8_pkg::S_DRAW_RD;
          end
          chip8_pkg::GRP_KEY: begin
            if (kk == chip8_pkg::KK_SKP && status.key_bit) begin
              cmd.pc_op = chip8_pkg::PC_ADD2;
            end else if (kk == chip8_pkg::KK_SKNP && !status.key_bit) begin
              cmd.pc_op = chip8_pkg::PC_ADD2;
            end
          end
          default: begin
            priority case (kk)
              chip8_pkg::KK_GETDT: begin
                cmd.v_we    = 1'b1;
                cmd.v_waddr = chip8_pkg::VA_X;
                cmd.v_wdata = chip8_pkg::VW_DT;
              end
              chip8_pkg::KK_WAITK: begin
                if (status.key_any) begin
                  cmd.v_we    = 1'b1;
                  cmd.v_waddr = chip8_pkg::VA_X;
                  cmd.v_wdata = chip8_pkg::VW_KEY;
                end else begin
                  cmd.pc_op = chip8_pkg::PC_BACK2;
                end
              end
              chip8_pkg::KK_SETDT: cmd.dt_ld = 1'b1;
              chip8_pkg::KK_SETST: cmd.st_ld = 1'b1;
              chip8_pkg::KK_ADDI:  cmd.idx_op = chip8_pkg::I_ADD;
              chip8_pkg::KK_FONT:  cmd.idx_op = chip8_pkg::I_FONT;
              chip8_pkg::KK_BCD: begin
                cmd.mem_we    = 1'b1;
                cmd.mem_addr  = chip8_pkg::MA_IDX;
                cmd.mem_wdata = chip8_pkg::MW_HUND;
                state_next    = chip8_pkg::S_BCD_T;
              end
              chip8_pkg::KK_STORE: begin
                cmd.cnt_clr = 1'b1;
                state_next  = chip8_pkg::S_STR_RD;
              end
              chip8_pkg::KK_LOAD: begin
                cmd.cnt_clr = 1'b1;
                state_next  = chip8_pkg::S_LD_RD;
              end
              default: cmd.unk_set = 1'b1;
            endcase
          end
        endcase
      end
      chip8_pkg::S_RET: begin
        cmd.pc_op  = chip8_pkg::PC_RET;
        state_next = chip8_pkg::S_TICK;
      end
      chip8_pkg::S_FLAG: begin
        cmd.v_we    = 1'b1;
        cmd.v_waddr = chip8_pkg::VA_FLAG;
        cmd.v_wdata = chip8_pkg::VW_FLAG;
        state_next  = chip8_pkg::S_TICK;
      end
      chip8_pkg::S_DRAW_RD: begin
        if (status.draw_go) begin
          cmd.mem_re   = 1'b1;
          cmd.mem_addr = chip8_pkg::MA_IDX_CNT;
          cmd.scr_re   = 1'b1;
          cmd.scr_row  = chip8_pkg::SR_DRAW;
          state_next   = chip8_pkg::S_DRAW_WR;
        end else begin
          state_next = chip8_pkg::S_FLAG;
        end
      end
      chip8_pkg::S_DRAW_WR: begin
        cmd.scr_we  = 1'b1;
        cmd.scr_row = chip8_pkg::SR_DRAW;
        cmd.flag_op = chip8_pkg::FL_HIT;
        cmd.cnt_inc = 1'b1;
        state_next  = chip8_pkg::S_DRAW_RD;
      end
      chip8_pkg::S_BCD_T: begin
        cmd.mem_we    = 1'b1;
        cmd.mem_addr  = chip8_pkg::MA_IDX1;
        cmd.mem_wdata = chip8_pkg::MW_TENS;
        state_next    = chip8_pkg::S_BCD_O;
      end
      chip8_pkg::S_BCD_O: begin
        cmd.mem_we    = 1'b1;
        cmd.mem_addr  = chip8_pkg::MA_IDX2;
        cmd.mem_wdata = chip8_pkg::MW_ONES;
        state_next    = chip8_pkg::S_TICK;
      end
      chip8_pkg::S_STR_RD: begin
        cmd.v_re    = 1'b1;
        cmd.v_raddr = chip8_pkg::VR_CNT;
        state_next  = chip8_pkg::S_STR_WR;
      end
      chip8_pkg::S_STR_WR: begin
        cmd.mem_we    = 1'b1;
        cmd.mem_addr  = chip8_pkg::MA_IDX_CNT;
        cmd.mem_wdata = chip8_pkg::MW_VQ;
        if (status.cnt_eq_x) begin
          state_next = chip8_pkg::S_TICK;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = chip8_pkg::S_STR_RD;
        end
      end
      chip8_pkg::S_LD_RD: begin
        cmd.mem_re   = 1'b1;
        cmd.mem_addr = chip8_pkg::MA_IDX_CNT;
        state_next   = chip8_pkg::S_LD_WR;
      end
      chip8_pkg::S_LD_WR: begin
        cmd.v_we    = 1'b1;
        cmd.v_waddr = chip8_pkg::VA_CNT;
        cmd.v_wdata = chip8_pkg::VW_MQ;
        if (status.cnt_eq_x) begin
          state_next = chip8_pkg::S_TICK;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = chip8_pkg::S_LD_RD;
        end
      end
      chip8_pkg::S_TICK: begin
        cmd.tick   = 1'b1;
        state_next = chip8_pkg::S_DONE;
      end
      chip8_pkg::S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = chip8_pkg::S_IDLE;
        end
      end
      default: state_next = chip8_pkg::S_IDLE;
    endcase
  end

endmodule

/* tb/chip8_instruction_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_instruction_core_tb
// drives write, execute, read and screen-row items into the core, keeps a model
// of memory, screen, registers, stack and timers, and compares every result beat
// with that model or a typed table row under random idling on both channels
// ----------------------------------------------------------------------------
module chip8_instruction_core_tb;

  logic                clk;
  logic                rst;
  logic                request_valid;
  logic                request_stall;
  chip8_pkg::request_t request;
  logic                result_valid;
  logic                result_stall;
  chip8_pkg::result_t  result;

  chip8_instruction_core u_top (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  // clock, 12 ns period
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  // shadow copy of the architectural state of the core
  logic [7:0]  shadow_mem [chip8_pkg::MEMORY_BYTES];
  logic [63:0] shadow_screen [chip8_pkg::SCREEN_HEIGHT];
  logic [7:0]  shadow_v [chip8_pkg::NUM_V];
  logic [15:0] shadow_i;
  logic [11:0] shadow_pc;
  logic [11:0] shadow_stack [chip8_pkg::STACK_DEPTH];
  logic [3:0]  shadow_sp;
  logic [7:0]  shadow_dt;
  logic [7:0]  shadow_st;
  int          call_depth;  // calls outstanding, keeps RET on written entries

  chip8_pkg::result_t expected_beats [$];
  int      mismatch_count = 0;
  bit      timed_out;

  // font copied from the package table so the model starts like the core
  task automatic shadow_reset();
    for (int a = 0; a < chip8_pkg::MEMORY_BYTES; a++)
      shadow_mem[a] = (a < chip8_pkg::FONT_BYTES) ? chip8_pkg::FONT_ROM[a] : 8'h00;
    for (int r = 0; r < chip8_pkg::SCREEN_HEIGHT; r++) shadow_screen[r] = '0;
    for (int k = 0; k < chip8_pkg::NUM_V; k++) shadow_v[k] = '0;
    shadow_i   = '0;
    shadow_pc  = chip8_pkg::PC_START;
    shadow_sp  = '0;
    shadow_dt  = '0;
    shadow_st  = '0;
    call_depth = 0;
  endtask

  // writes into the font area are dropped
  function automatic void shadow_store(input logic [31:0] a, input logic [7:0] d);
    logic [11:0] w;
    w = a[11:0];
    if (w >= chip8_pkg::FONT_BYTES) shadow_mem[w] = d;
  endfunction

  // one instruction at the current pc
  function automatic void shadow_execute(input logic [15:0] keys, input logic [7:0] rnd,
                                         output logic disp, output logic unk);
    logic [15:0] opc;
    logic [3:0]  x, y, n;
    logic [7:0]  kk, a, b;
    logic [11:0] nnn;
    logic [5:0]  cx;
    logic [4:0]  cy;
    logic [63:0] spr;
    logic        hit;
    int          found;
    opc  = {shadow_mem[shadow_pc], shadow_mem[shadow_pc + 12'd1]};
    x    = opc[11:8];
    y    = opc[7:4];
    n    = opc[3:0];
    kk   = opc[7:0];
    nnn  = opc[11:0];
    disp = 1'b0;
    unk  = 1'b0;
    shadow_pc = shadow_pc + 12'd2;
    case (opc[15:12])
      chip8_pkg::GRP_SYS: begin
        if (kk == chip8_pkg::KK_CLS) begin
          for (int r = 0; r < chip8_pkg::SCREEN_HEIGHT; r++) shadow_screen[r] = '0;
          disp = 1'b1;
        end else if (kk == chip8_pkg::KK_RET && x == 4'h0) begin
          shadow_sp  = shadow_sp - 4'd1;
          shadow_pc  = shadow_stack[shadow_sp];
          call_depth = call_depth - 1;
        end
      end
      chip8_pkg::GRP_JP: shadow_pc = nnn;
      chip8_pkg::GRP_CALL: begin
        shadow_stack[shadow_sp] = shadow_pc;
        shadow_sp  = shadow_sp + 4'd1;
        shadow_pc  = nnn;
        call_depth = call_depth + 1;
      end
      chip8_pkg::GRP_SE:   if (shadow_v[x] == kk) shadow_pc = shadow_pc + 12'd2;
      chip8_pkg::GRP_SNE:  if (shadow_v[x] != kk) shadow_pc = shadow_pc + 12'd2;
      chip8_pkg::GRP_SEV:  if (shadow_v[x] == shadow_v[y]) shadow_pc = shadow_pc + 12'd2;
      chip8_pkg::GRP_LD:   shadow_v[x] = kk;
      chip8_pkg::GRP_ADD:  shadow_v[x] = shadow_v[x] + kk;
      chip8_pkg::GRP_ALU: begin
        a = shadow_v[x];
        b = shadow_v[y];
        // flag register written last
        case (n)
          chip8_pkg::ALU_MOV:  shadow_v[x] = b;
          chip8_pkg::ALU_OR:   shadow_v[x] = a | b;
          chip8_pkg::ALU_AND:  shadow_v[x] = a & b;
          chip8_pkg::ALU_XOR:  shadow_v[x] = a ^ b;
          chip8_pkg::ALU_ADD: begin
            shadow_v[x] = a + b;
            shadow_v[chip8_pkg::FLAG_REG] = {7'd0, ({1'b0, a} + {1'b0, b}) > 9'hFF};
          end
          chip8_pkg::ALU_SUB: begin
            shadow_v[x] = a - b;
            shadow_v[chip8_pkg::FLAG_REG] = {7'd0, a > b};
          end
          chip8_pkg::ALU_SHR: begin
            shadow_v[x] = a >> 1;
            shadow_v[chip8_pkg::FLAG_REG] = {7'd0, a[0]};
          end
          chip8_pkg::ALU_SUBN: begin
            shadow_v[x] = b - a;
            shadow_v[chip8_pkg::FLAG_REG] = {7'd0, b > a};
          end
          chip8_pkg::ALU_SHL: begin
            shadow_v[x] = a << 1;
            shadow_v[chip8_pkg::FLAG_REG] = {7'd0, a[7]};
          end
          default: ;
        endcase
      end
      chip8_pkg::GRP_SNEV: if (shadow_v[x] != shadow_v[y]) shadow_pc = shadow_pc + 12'd2;
      chip8_pkg::GRP_LDI:  shadow_i = {4'h0, nnn};
      chip8_pkg::GRP_JPV:  shadow_pc = nnn + 12'(shadow_v[0]);
      chip8_pkg::GRP_RND:  shadow_v[x] = rnd & kk;
      chip8_pkg::GRP_DRW: begin
        cx  = shadow_v[x][5:0];
        cy  = shadow_v[y][4:0];
        hit = 1'b0;
        // clipped at the bottom edge
        for (int r = 0; r < n && cy + r < chip8_pkg::SCREEN_HEIGHT; r++) begin
          spr = {shadow_mem[12'(shadow_i + r)], 56'd0} >> cx;
          if ((shadow_screen[cy + r] & spr) != 0) hit = 1'b1;
          shadow_screen[cy + r] ^= spr;
        end
        shadow_v[chip8_pkg::FLAG_REG] = {7'd0, hit};
        disp = 1'b1;
      end
      chip8_pkg::GRP_KEY: begin
        if (kk == chip8_pkg::KK_SKP && keys[shadow_v[x][3:0]])
          shadow_pc = shadow_pc + 12'd2;
        else if (kk == chip8_pkg::KK_SKNP && !keys[shadow_v[x][3:0]])
          shadow_pc = shadow_pc + 12'd2;
      end
      default: begin
        case (kk)
          chip8_pkg::KK_GETDT: shadow_v[x] = shadow_dt;
          chip8_pkg::KK_WAITK: begin
            found = -1;
            for (int k = 15; k >= 0; k--) if (keys[k]) found = k;
            if (found >= 0) shadow_v[x] = 8'(found);
            else shadow_pc = shadow_pc - 12'd2;
          end
          chip8_pkg::KK_SETDT: shadow_dt = shadow_v[x];
          chip8_pkg::KK_SETST: shadow_st = shadow_v[x];
          chip8_pkg::KK_ADDI:  shadow_i = shadow_i + 16'(shadow_v[x]);
          chip8_pkg::KK_FONT:  shadow_i = 16'(shadow_v[x][3:0] * 16'd5);
          chip8_pkg::KK_BCD: begin
            shadow_store(32'(shadow_i), 8'(shadow_v[x] / 100));
            shadow_store(32'(shadow_i) + 32'd1, 8'((shadow_v[x] / 10) % 10));
            shadow_store(32'(shadow_i) + 32'd2, 8'(shadow_v[x] % 10));
          end
          chip8_pkg::KK_STORE:
            for (int k = 0; k <= x; k++) shadow_store(32'(shadow_i) + 32'(k), shadow_v[k]);
          chip8_pkg::KK_LOAD:
            for (int k = 0; k <= x; k++) shadow_v[k] = shadow_mem[12'(shadow_i + k)];
          default: unk = 1'b1;
        endcase
      end
    endcase
    if (shadow_dt != 0) shadow_dt--;
    if (shadow_st != 0) shadow_st--;
  endfunction

  // expected result beat for one accepted item
  function automatic chip8_pkg::result_t shadow_step(input chip8_pkg::request_t req);
    chip8_pkg::result_t res;
    logic        disp, unk;
    logic [63:0] data;
    disp = 1'b0;
    unk  = 1'b0;
    data = '0;
    case (chip8_pkg::item_op_t'(req.operation))
      chip8_pkg::OP_WRITE: shadow_store(32'(req.address), req.write_byte);
      chip8_pkg::OP_EXEC:  shadow_execute(req.key_state, req.random_byte, disp, unk);
      chip8_pkg::OP_READ:  data = {56'd0, shadow_mem[req.address]};
      default:             data = shadow_screen[req.address[4:0]];
    endcase
    res.program_counter = shadow_pc;
    res.display_changed = disp;
    res.sound_on        = shadow_st != 0;
    res.unknown_opcode  = unk;
    res.read_data       = data;
    return res;
  endfunction

  // ------------------------------------------------------------- stimulus
  bit      send_calm;        // no random idling while set
  bit      hold_off;         // long receiver hold-off already done

  function automatic chip8_pkg::request_t make_item(input chip8_pkg::item_op_t op,
                                                    input logic [11:0] addr,
                                                    input logic [7:0] wb,
                                                    input logic [15:0] keys,
                                                    input logic [7:0] rnd);
    chip8_pkg::request_t r;
    r.operation   = op;
    r.address     = addr;
    r.write_byte  = wb;
    r.key_state   = keys;
    r.random_byte = rnd;
    return r;
  endfunction

  // one beat on the request channel; the model runs when it is accepted
  task automatic send_beat(input chip8_pkg::request_t req, input bit typed_check,
                           input chip8_pkg::result_t typed_res);
    chip8_pkg::result_t exp;
    while (!send_calm && $urandom_range(99) < 16) begin
      request_valid <= 1'b0;
      @(posedge clk);
    end
    request_valid <= 1'b1;
    request       <= req;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    exp = shadow_step(req);
    if (typed_check && exp !== typed_res)
      $display("table row disagrees with model: %h vs %h", typed_res, exp);
    expected_beats.push_back(typed_check ? typed_res : exp);
  endtask

  // next instruction written at pc and pc+1, then executed
  task automatic run_opcode(input logic [15:0] opc, input logic [15:0] keys,
                            input logic [7:0] rnd);
    chip8_pkg::result_t none;
    none = '0;
    send_beat(make_item(chip8_pkg::OP_WRITE, shadow_pc, opc[15:8], '0, '0), 1'b0, none);
    send_beat(make_item(chip8_pkg::OP_WRITE, shadow_pc + 12'd1, opc[7:0], '0, '0),
              1'b0, none);
    send_beat(make_item(chip8_pkg::OP_EXEC, 12'($urandom), 8'($urandom), keys, rnd),
              1'b0, none);
  endtask

  // random instruction that never returns from an unwritten stack entry
  function automatic logic [15:0] random_opcode();
    logic [15:0] o;
    o = 16'($urandom);
    case ($urandom_range(19))
      0:  o = {chip8_pkg::GRP_SYS, 4'h0, chip8_pkg::KK_CLS};
      1:  o = (call_depth > 0) ? {chip8_pkg::GRP_SYS, 4'h0, chip8_pkg::KK_RET}
                               : {chip8_pkg::GRP_LD, o[11:0]};
      2:  o = {chip8_pkg::GRP_SYS, o[11:0]};
      3:  o = {chip8_pkg::GRP_ALU, o[11:4], chip8_pkg::ALU_ADD};
      4:  o = {chip8_pkg::GRP_ALU, o[11:4], chip8_pkg::ALU_SUB};
      5:  o = {chip8_pkg::GRP_ALU, o[11:4], chip8_pkg::ALU_SHR};
      6:  o = {chip8_pkg::GRP_ALU, o[11:4], chip8_pkg::ALU_SUBN};
      7:  o = {chip8_pkg::GRP_ALU, o[11:4], chip8_pkg::ALU_SHL};
      8:  o = {chip8_pkg::GRP_KEY, o[11:8],
               ($urandom_range(1) ? chip8_pkg::KK_SKP : chip8_pkg::KK_SKNP)};
      9:  o = {chip8_pkg::GRP_MISC, o[11:8], chip8_pkg::KK_WAITK};
      10: o = {chip8_pkg::GRP_MISC, o[11:8], chip8_pkg::KK_SETST};
      11: o = {chip8_pkg::GRP_MISC, o[11:8], chip8_pkg::KK_BCD};
      12: o = {chip8_pkg::GRP_MISC, o[11:8], chip8_pkg::KK_STORE};
      13: o = {chip8_pkg::GRP_MISC, o[11:8], chip8_pkg::KK_LOAD};
      14: o = {chip8_pkg::GRP_DRW, o[11:4], 4'($urandom_range(15))};
      15: o = {chip8_pkg::GRP_MISC, o[11:8], chip8_pkg::KK_FONT};
      default: ;
    endcase
    if (o[15:12] == chip8_pkg::GRP_SYS && o[7:0] == chip8_pkg::KK_RET &&
        o[11:8] == 4'h0 && call_depth == 0)
      o = {chip8_pkg::GRP_LD, o[11:0]};
    return o;
  endfunction

  // directed table: typed rows carry their expected result
  typedef struct {
    chip8_pkg::request_t req;
    bit                  typed;
    chip8_pkg::result_t  res;
  } table_row_t;

  table_row_t directed_rows [$];

  task automatic add_row(input chip8_pkg::request_t req, input bit typed,
                         input chip8_pkg::result_t res);
    table_row_t t;
    t.req   = req;
    t.typed = typed;
    t.res   = res;
    directed_rows.push_back(t);
  endtask

  function automatic chip8_pkg::result_t typed_res(input logic [11:0] pc,
                                                   input logic [63:0] d);
    chip8_pkg::result_t r;
    r = '0;
    r.program_counter = pc;
    r.read_data       = d;
    return r;
  endfunction

  initial begin : stimulus
    logic [15:0] opc;
    logic [15:0] keys;
    rst           = 1'b1;
    request_valid = 1'b0;
    request       = '0;
    send_calm     = 1'b0;
    shadow_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset values, font bytes and the write drop on the font
    add_row(make_item(chip8_pkg::OP_READ, 12'd0, 8'h00, '0, '0), 1,
            typed_res(chip8_pkg::PC_START, 64'hF0));
    add_row(make_item(chip8_pkg::OP_READ, 12'd79, 8'h00, '0, '0), 1,
            typed_res(chip8_pkg::PC_START, 64'h80));
    add_row(make_item(chip8_pkg::OP_WRITE, 12'd0, 8'hFF, 16'hFFFF, 8'hFF), 1,
            typed_res(chip8_pkg::PC_START, 0));
    add_row(make_item(chip8_pkg::OP_READ, 12'd0, 8'h00, '0, '0), 1,
            typed_res(chip8_pkg::PC_START, 64'hF0));
    add_row(make_item(chip8_pkg::OP_WRITE, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF), 1,
            typed_res(chip8_pkg::PC_START, 0));
    add_row(make_item(chip8_pkg::OP_READ, 12'hFFF, 8'h00, '0, '0), 1,
            typed_res(chip8_pkg::PC_START, 64'hFF));
    add_row(make_item(chip8_pkg::OP_ROW, 12'hFFF, 8'h00, '0, '0), 1,
            typed_res(chip8_pkg::PC_START, 0));
    add_row(make_item(chip8_pkg::OP_READ, 12'd80, 8'h00, '0, '0), 1,
            typed_res(chip8_pkg::PC_START, 0));
    foreach (directed_rows[k]) send_beat(directed_rows[k].req, directed_rows[k].typed,
                                         directed_rows[k].res);

    // ld, alu, ldi, drw, call, ret, rnd and misc, with flags, edges and the wait for key
    run_opcode({chip8_pkg::GRP_LD, 4'h0, 8'hFF}, '0, '0);
    run_opcode({chip8_pkg::GRP_LD, 4'h1, 8'h01}, '0, '0);
    run_opcode({chip8_pkg::GRP_ALU, 4'h0, 4'h1, chip8_pkg::ALU_ADD}, '0, '0);   // carry out
    run_opcode({chip8_pkg::GRP_ALU, 4'h2, 4'h1, chip8_pkg::ALU_SUB}, '0, '0);
    run_opcode({chip8_pkg::GRP_ALU, 4'h1, 4'h2, chip8_pkg::ALU_SUBN}, '0, '0);
    run_opcode({chip8_pkg::GRP_ALU, 4'hF, 4'h1, chip8_pkg::ALU_SHL}, '0, '0);   // flag target
    run_opcode({chip8_pkg::GRP_LD, 4'h3, 8'd63}, '0, '0);
    run_opcode({chip8_pkg::GRP_LD, 4'h4, 8'd31}, '0, '0);
    run_opcode({chip8_pkg::GRP_LDI, 12'd0}, '0, '0);
    run_opcode({chip8_pkg::GRP_DRW, 4'h3, 4'h4, 4'hF}, '0, '0);      // clipped at corner
    run_opcode({chip8_pkg::GRP_DRW, 4'h3, 4'h4, 4'h0}, '0, '0);
    send_beat(make_item(chip8_pkg::OP_ROW, 12'd31, '0, '0, '0), 0, '0);
    run_opcode({chip8_pkg::GRP_MISC, 4'h5, chip8_pkg::KK_WAITK}, 16'h0000, '0);
    run_opcode({chip8_pkg::GRP_MISC, 4'h5, chip8_pkg::KK_WAITK}, 16'h8000, '0);
    run_opcode({chip8_pkg::GRP_CALL, 12'hFFE}, '0, '0);
    run_opcode({chip8_pkg::GRP_SYS, 4'h0, chip8_pkg::KK_RET}, '0, '0);
    run_opcode({chip8_pkg::GRP_MISC, 4'h0, 8'hFF}, 16'hFFFF, 8'hFF);   // unknown code
    run_opcode({chip8_pkg::GRP_RND, 4'h7, 8'h0F}, '0, 8'hFF);
    run_opcode({chip8_pkg::GRP_MISC, 4'h0, chip8_pkg::KK_SETST}, '0, '0);

    // random part: mostly instructions planted at pc, some plain memory traffic
    for (int k = 0; k < 160; k++) begin
      if (k == 20) send_calm = 1'b1;
      if (k == 60) send_calm = 1'b0;
      keys = ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom);
      case ($urandom_range(9))
        0: send_beat(make_item(chip8_pkg::OP_WRITE, 12'($urandom), 8'($urandom),
                               16'($urandom), 8'($urandom)), 0, '0);
        1: send_beat(make_item(chip8_pkg::OP_READ, 12'($urandom), 8'($urandom),
                               16'($urandom), 8'($urandom)), 0, '0);
        2: send_beat(make_item(chip8_pkg::OP_ROW, 12'($urandom), 8'($urandom),
                               16'($urandom), 8'($urandom)), 0, '0);
        default: begin
          opc = random_opcode();
          run_opcode(opc, keys, 8'($urandom));
        end
      endcase
    end
    request_valid <= 1'b0;

    // drain, then wait out a margin before the verdict
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && !timed_out) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ------------------------------------------------------------- receiver
  int hold_cycles;

  initial begin
    result_stall = 1'b0;
    hold_cycles  = 0;
    hold_off     = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        result_stall <= 1'b1;
      end else if (!rst && send_calm && !hold_off) begin
        // long hold-off while requests keep coming
        hold_cycles = 200;
        hold_off    = 1'b1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !send_calm && ($urandom_range(99) < 16);
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    chip8_pkg::result_t exp;
    if (!rst && result_valid && !result_stall) begin
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat %h", result);
      end else begin
        exp = expected_beats.pop_front();
        if (result.program_counter !== exp.program_counter ||
            result.display_changed !== exp.display_changed ||
            result.sound_on !== exp.sound_on ||
            result.unknown_opcode !== exp.unknown_opcode ||
            result.read_data !== exp.read_data) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: pc %h/%h disp %b/%b snd %b/%b unk %b/%b data %h/%h",
                     exp.program_counter, result.program_counter,
                     exp.display_changed, result.display_changed,
                     exp.sound_on, result.sound_on,
                     exp.unknown_opcode, result.unknown_opcode,
                     exp.read_data, result.read_data);
        end
      end
    end
  end

  // watchdog: clearing sweep plus generous per-item budget
  int cycle_count;

  initial begin
    timed_out   = 1'b0;
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        timed_out = 1'b1;
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
